// ===== rtl/core/rfc_pkg.sv =====
package rfc_pkg;

  localparam int unsigned CountWidth = 6;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned RegIndexWidth = 2;

  localparam logic [RegIndexWidth-1:0] REG_EXPECTED_LENGTH = 2'd0;
  localparam logic [RegIndexWidth-1:0] REG_STATUS_POSITION = 2'd1;
  localparam logic [RegIndexWidth-1:0] REG_STATION_ID      = 2'd2;
  localparam logic [RegIndexWidth-1:0] REG_MAX_ATTEMPTS    = 2'd3;

  localparam logic [5:0] RESET_EXPECTED_LENGTH = 6'd7;
  localparam logic [4:0] RESET_STATUS_POSITION = 5'd4;
  localparam logic [7:0] RESET_STATION_ID      = 8'd80;
  localparam logic [2:0] RESET_MAX_ATTEMPTS    = 3'd3;

  localparam logic [7:0] CODE_SOH    = 8'h01;
  localparam logic [7:0] CODE_STX    = 8'h02;
  localparam logic [7:0] STATUS_GOOD = 8'h30;
  localparam logic [7:0] STATUS_STOP = 8'h31;
  localparam logic [CountWidth-1:0] MIN_FRAME = 6'd4;

  localparam logic OPCODE_BYTE  = 1'b0;
  localparam logic OPCODE_CLOSE = 1'b1;

  localparam logic REPLY_ACK = 1'b0;
  localparam logic REPLY_NAK = 1'b1;

  localparam logic [2:0] OUT_RETRY  = 3'd0;
  localparam logic [2:0] OUT_GOOD   = 3'd1;
  localparam logic [2:0] OUT_DEVERR = 3'd2;
  localparam logic [2:0] OUT_BADLEN = 3'd3;
  localparam logic [2:0] OUT_GAVEUP = 3'd4;

  typedef struct packed {
    logic                     en;
    logic [RegIndexWidth-1:0] index;
    logic [ByteWidth-1:0]     data;
  } cfg_write_t;

  typedef struct packed {
    logic                  reply;
    logic [2:0]            outcome;
    logic [ByteWidth-1:0]  device_code;
    logic [CountWidth-1:0] received_count;
  } result_t;

endpackage

// ===== rtl/core/rfc_tracker.sv =====
module rfc_tracker #(
  parameter int unsigned MAX_FRAME = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  rfc_pkg::cfg_write_t cfg,
  input  logic                take,
  input  logic                opcode,
  input  logic [7:0]          rx_byte,
  output logic                result_valid,
  output rfc_pkg::result_t    result
);

  localparam int unsigned LimCapInt = (MAX_FRAME > 63) ? 63 : MAX_FRAME;
  localparam logic [5:0] LIM_CAP = 6'(LimCapInt);

  logic [5:0] expected_length;
  logic [4:0] status_position;
  logic [7:0] station_id;
  logic [2:0] max_attempts;

  logic [5:0] byte_count;
  logic [7:0] xor_sum;
  logic       header_good;
  logic [7:0] status_byte;
  logic [2:0] attempts_left;

  logic [5:0] count_next;
  logic [7:0] xor_next;
  logic       header_next;
  logic [7:0] status_next;
  logic [5:0] frame_limit;
  logic       close;
  logic       bad;
  logic [2:0] outcome;
  logic [2:0] attempts_next;

  always_comb begin
    if (expected_length > LIM_CAP) begin
      frame_limit = LIM_CAP;
    end else if (expected_length == 6'd0) begin
      frame_limit = 6'd1;
    end else begin
      frame_limit = expected_length;
    end
  end

  always_comb begin
    count_next  = byte_count;
    xor_next    = xor_sum;
    header_next = header_good;
    status_next = status_byte;
    close       = 1'b0;
    if (opcode == rfc_pkg::OPCODE_CLOSE) begin
      close = 1'b1;
    end else begin
      if (byte_count == 6'd0 && rx_byte != rfc_pkg::CODE_SOH) header_next = 1'b0;
      if (byte_count == 6'd1 && rx_byte != station_id) header_next = 1'b0;
      if (byte_count == 6'd2 && rx_byte != rfc_pkg::CODE_STX) header_next = 1'b0;
      if (byte_count == {1'b0, status_position}) status_next = rx_byte;
      xor_next   = xor_sum ^ rx_byte;
      count_next = byte_count + 6'd1;
      close      = (count_next >= frame_limit);
    end
  end

  always_comb begin
    bad = (count_next < rfc_pkg::MIN_FRAME) || (xor_next != 8'd0) || !header_next;
    attempts_next = max_attempts;
    if (bad) begin
      if (attempts_left > 3'd1) begin
        attempts_next = attempts_left - 3'd1;
        outcome = rfc_pkg::OUT_RETRY;
      end else begin
        outcome = rfc_pkg::OUT_GAVEUP;
      end
    end else if (count_next != expected_length) begin
      outcome = rfc_pkg::OUT_BADLEN;
    end else if (status_next == rfc_pkg::STATUS_GOOD ||
                 status_next == rfc_pkg::STATUS_STOP) begin
      outcome = rfc_pkg::OUT_GOOD;
    end else begin
      outcome = rfc_pkg::OUT_DEVERR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_length <= rfc_pkg::RESET_EXPECTED_LENGTH;
      status_position <= rfc_pkg::RESET_STATUS_POSITION;
      station_id      <= rfc_pkg::RESET_STATION_ID;
      max_attempts    <= rfc_pkg::RESET_MAX_ATTEMPTS;
      byte_count      <= 6'd0;
      xor_sum         <= 8'd0;
      header_good     <= 1'b1;
      status_byte     <= 8'd0;
      attempts_left   <= rfc_pkg::RESET_MAX_ATTEMPTS;
      result_valid    <= 1'b0;
    end else begin
      result_valid <= take && close;
      if (take) begin
        if (close) begin
          byte_count    <= 6'd0;
          xor_sum       <= 8'd0;
          header_good   <= 1'b1;
          status_byte   <= 8'd0;
          attempts_left <= attempts_next;
        end else begin
          byte_count  <= count_next;
          xor_sum     <= xor_next;
          header_good <= header_next;
          status_byte <= status_next;
        end
      end
      if (cfg.en) begin
        case (cfg.index)
          rfc_pkg::REG_EXPECTED_LENGTH: expected_length <= cfg.data[5:0];
          rfc_pkg::REG_STATUS_POSITION: status_position <= cfg.data[4:0];
          rfc_pkg::REG_STATION_ID:      station_id      <= cfg.data;
          rfc_pkg::REG_MAX_ATTEMPTS: begin
            max_attempts  <= cfg.data[2:0];
            attempts_left <= cfg.data[2:0];
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && close) begin
      result.reply          <= bad ? rfc_pkg::REPLY_NAK : rfc_pkg::REPLY_ACK;
      result.outcome        <= outcome;
      result.device_code    <= status_next;
      result.received_count <= count_next;
    end
  end

endmodule

// ===== rtl/core/rfc_out_buffer.sv =====
module rfc_out_buffer (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  rfc_pkg::result_t load_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output rfc_pkg::result_t out_data
);

  logic             skid_valid;
  rfc_pkg::result_t skid_data;
  logic             out_xfer;

  assign out_xfer = out_valid && !out_stall;
  // a result landing in the skid entry this cycle also blocks the input,
  // so the next result can never meet an occupied skid entry
  assign full     = skid_valid || (load && out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_xfer) begin
          out_data   <= skid_data;
          skid_valid <= 1'b0;
        end
      end else if (load) begin
        if (!out_valid || out_xfer) begin
          out_data  <= load_data;
          out_valid <= 1'b1;
        end else begin
          skid_data  <= load_data;
          skid_valid <= 1'b1;
        end
      end else if (out_xfer) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/response_frame_checker_unit.sv =====
// Response frame checker.
// Input channel (in_valid / in_stall): one transfer per received byte
// (opcode 0, rx_byte) or per early read-window close (opcode 1).
// Output channel (out_valid / out_stall): one transfer per closed frame with
// reply (ACK/NAK), outcome, device_code and received_count.
// Configuration: wr_en, wr_index, wr_data write one register per cycle;
// write only while no frame result is outstanding.
// Throughput: one input transfer per cycle while in_stall is low. The whole
// per-byte update and frame judgement is combinational into the result
// register, and the result then passes through the output register before
// out_valid rises.
// The output stage holds one result plus one skid entry. When a result
// arrives while the receiver stalls a full output register, in_stall rises in
// that cycle and stays high until the skid entry drains.
// Reset (rst, synchronous) loads the register defaults, clears the frame
// state, reloads the attempt counter and empties the output stage.
module response_frame_checker_unit #(
  parameter int unsigned MAX_FRAME = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  logic [1:0] wr_index,
  input  logic [7:0] wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       opcode,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       reply,
  output logic [2:0] outcome,
  output logic [7:0] device_code,
  output logic [5:0] received_count
);

  rfc_pkg::cfg_write_t cfg;
  rfc_pkg::result_t    frame_result;
  rfc_pkg::result_t    out_data;
  logic                frame_done;
  logic                full;
  logic                take;

  assign cfg.en    = wr_en;
  assign cfg.index = wr_index;
  assign cfg.data  = wr_data;

  assign in_stall = full;
  assign take     = in_valid && !full;

  rfc_tracker #(
    .MAX_FRAME(MAX_FRAME)
  ) u_tracker (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .take        (take),
    .opcode      (opcode),
    .rx_byte     (rx_byte),
    .result_valid(frame_done),
    .result      (frame_result)
  );

  rfc_out_buffer u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (frame_done),
    .load_data(frame_result),
    .full     (full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  assign reply          = out_data.reply;
  assign outcome        = out_data.outcome;
  assign device_code    = out_data.device_code;
  assign received_count = out_data.received_count;

endmodule
